// File: src/x86_stack_frame_engine_core_assert.svh
// Assertion macros shared by the stack frame engine RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef X86_STACK_FRAME_ENGINE_CORE_ASSERT_SVH
`define X86_STACK_FRAME_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define SFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sfe_pkg.sv
// Shared constants, types and helper functions of the stack frame engine.
// No dependencies; imported by sfe_bounds and the top level.
package sfe_pkg;

    localparam int STACK_WORDS_DEF = 1024;
    localparam logic [63:0] WORD_BYTES = 64'd8;

    // Operation codes
    localparam logic [2:0] OP_ENTER  = 3'd0;
    localparam logic [2:0] OP_LEAVE  = 3'd1;
    localparam logic [2:0] OP_PUSHFQ = 3'd2;
    localparam logic [2:0] OP_POPFQ  = 3'd3;
    localparam logic [2:0] OP_PUSH   = 3'd4;
    localparam logic [2:0] OP_POP    = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_NEST   = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    // Pop destination kinds
    localparam logic [1:0] DK_REG = 2'd0;
    localparam logic [1:0] DK_MEM = 2'd1;

    // Configuration register indexes and reset values
    localparam int         CFG_INDEX_W    = 2;
    localparam logic [1:0] CFG_STACK_LOW  = 2'd0;
    localparam logic [1:0] CFG_STACK_HIGH = 2'd1;
    localparam logic [63:0] STACK_LOW_RST  = 64'd0;
    localparam logic [63:0] STACK_HIGH_RST = 64'd8192;

    // Result of one window check: pass flag and word offset from stack_low
    typedef struct packed {
        logic        ok;
        logic [60:0] offs;
    } t_chk;

    // Keep the low operand_bytes bytes of a word
    function automatic logic [63:0] size_mask(input logic [3:0] bytes);
        logic [63:0] m;
        case (bytes)
            4'd0:    m = 64'h0000_0000_0000_0000;
            4'd1:    m = 64'h0000_0000_0000_00FF;
            4'd2:    m = 64'h0000_0000_0000_FFFF;
            4'd3:    m = 64'h0000_0000_00FF_FFFF;
            4'd4:    m = 64'h0000_0000_FFFF_FFFF;
            4'd5:    m = 64'h0000_00FF_FFFF_FFFF;
            4'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
            4'd7:    m = 64'h00FF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// File: src/sfe_stack_mem.sv
// Stack word memory: one write port and one registered read port.
// Depends on nothing outside this file.
module sfe_stack_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0] r_words [DEPTH];
    logic [63:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_words[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_words[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sfe_bounds.sv
// Stack window check for one access plus its word offset from stack_low.
// Depends on sfe_pkg for the check result type.
module sfe_bounds
    import sfe_pkg::*;
(
    input  logic [63:0] i_addr,
    input  logic [63:0] i_low,
    input  logic [63:0] i_high_m_len,
    input  logic        i_len_ok,
    output t_chk        o_chk
);

    logic [64:0] diff;

    // Borrow of addr - low flags an address under the window
    assign diff       = {1'b0, i_addr} - {1'b0, i_low};
    assign o_chk.ok   = !diff[64] && i_len_ok && (i_addr <= i_high_m_len);
    assign o_chk.offs = diff[63:3];

endmodule

// File: src/sfe_word_index.sv
// Reduces a word offset modulo the stack depth into a memory index.
// Power-of-two depths register the low offset bits directly; others reduce eight bits a cycle.
module sfe_word_index #(
    parameter int DEPTH = 1024,
    parameter int IW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [60:0]   i_offs,
    output logic          o_done,
    output logic [IW-1:0] o_idx
);

    localparam bit POW2 = (DEPTH & (DEPTH - 1)) == 0;

    logic          r_done;
    logic [IW-1:0] r_idx;

    generate
        if (POW2) begin : g_pow2
            // Take the low bits directly
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_done <= 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_idx <= i_offs[IW-1:0];
                end
            end
        end else begin : g_mod
            localparam logic [IW:0] DEP1 = (IW+1)'(DEPTH);

            logic          r_busy;
            logic [2:0]    r_cnt;
            logic [63:0]   r_shreg;
            logic [IW-1:0] n_rem;

            // Shift eight offset bits into the remainder, MSB first
            always_comb begin : p_reduce
                logic [IW:0]   v;
                logic [IW-1:0] rem;
                rem = r_idx;
                for (int k = 0; k < 8; k++) begin
                    v = {rem, r_shreg[63-k]};
                    if (v >= DEP1) begin
                        v = v - DEP1;
                    end
                    rem = v[IW-1:0];
                end
                n_rem = rem;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= 3'd0;
                end else if (i_start) begin
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                    r_cnt  <= 3'd0;
                end else if (r_busy) begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_shreg <= {3'b000, i_offs};
                    r_idx   <= '0;
                end else if (r_busy) begin
                    r_shreg <= {r_shreg[55:0], 8'h00};
                    r_idx   <= n_rem;
                end
            end
        end
    endgenerate

    assign o_done = r_done;
    assign o_idx  = r_idx;

endmodule

// File: src/x86_stack_frame_engine_core.sv
// Stack frame engine top level: config registers, sequencer, result register.
// Depends on sfe_pkg, sfe_stack_mem, sfe_bounds, sfe_word_index and the
// assertion macro header.
//
// Usage:
// - Configuration: write stack_low (index 0) and stack_high (index 1) on the
//   cfg channel while the block is idle; o_cfg_ready is always high.
// - Input channel i_valid/o_ready takes one stack instruction with the
//   current stack pointer, frame pointer and flags. o_ready is high only
//   while the sequencer is idle, so one item is in work at a time.
// - Each item walks address, check, index, memory and finish steps, with one
//   more step for LEAVE, POPFQ and POP, which wait on the memory read.
//   o_valid rises once the finish step loads the output register. With a
//   stack depth that is not a power of two the index step waits for the
//   modulo reduction in sfe_word_index.
// - The result sits in an output register. A new item is taken while it
//   waits; if the receiver still stalls when the next result is ready, the
//   sequencer holds in its finish step until the register frees.
// - Reset restores stack_low 0 and stack_high 8192 and empties the output
//   register; stack memory contents stay undefined until pushed.
`include "x86_stack_frame_engine_core_assert.svh"

module x86_stack_frame_engine_core
    import sfe_pkg::*;
#(
    parameter int STACK_WORDS = STACK_WORDS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    // input item channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2:0]             i_op,
    input  logic [63:0]            i_stack_ptr_in,
    input  logic [63:0]            i_frame_ptr_in,
    input  logic [63:0]            i_flags_in,
    input  logic [63:0]            i_push_value,
    input  logic [3:0]             i_operand_bytes,
    input  logic [15:0]            i_frame_size,
    input  logic [4:0]             i_nesting_level,
    input  logic [1:0]             i_dest_kind,
    input  logic [63:0]            i_dest_addr,
    // result item channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_status,
    output logic [63:0]            o_stack_ptr_out,
    output logic [63:0]            o_frame_ptr_out,
    output logic                   o_reg_write_valid,
    output logic [63:0]            o_reg_data,
    output logic                   o_mem_write_valid,
    output logic [63:0]            o_mem_addr,
    output logic [63:0]            o_mem_data,
    output logic                   o_flags_write_valid,
    output logic [63:0]            o_flags_data
);

    localparam int IW = $clog2(STACK_WORDS);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADDR = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_IDX  = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [63:0] r_stack_low, r_stack_high;

    // captured item
    logic [2:0]  r_op;
    logic [63:0] r_sp, r_fp, r_flags, r_pval, r_daddr;
    logic [3:0]  r_obytes;
    logic [15:0] r_fsize;
    logic [4:0]  r_nest;
    logic [1:0]  r_dkind;

    // address step results
    logic [63:0] r_t, r_t2, r_sp_p8, r_fp_p8;
    logic [63:0] r_hi_m8, r_hi_mf, r_hi_mo;
    logic        r_len8_ok, r_lenf_ok, r_leno_ok;

    // check step results
    logic        r_ok1, r_ok2, r_okd;

    logic        in_acc, cfg_acc, fin_load;
    logic        op_write, op_read, pop_win_wr;
    logic [63:0] addr1, push_data;
    t_chk        chk1, chk2, chkd;
    logic        idx1_done, idxd_done;
    logic [IW-1:0] idx1, idxd;

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr;
    logic [63:0]   mem_wdata, mem_rdata;

    // next result
    logic [1:0]  res_status;
    logic [63:0] res_sp, res_fp, res_reg_data, res_mem_addr, res_mem_data, res_flags;
    logic        res_reg_wv, res_mem_wv, res_flags_wv;

    logic        r_out_valid, n_out_valid;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign in_acc      = i_valid && o_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_low  <= STACK_LOW_RST;
            r_stack_high <= STACK_HIGH_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                CFG_STACK_LOW:  r_stack_low  <= i_cfg_data;
                CFG_STACK_HIGH: r_stack_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_op;
            r_sp     <= i_stack_ptr_in;
            r_fp     <= i_frame_ptr_in;
            r_flags  <= i_flags_in;
            r_pval   <= i_push_value;
            r_obytes <= i_operand_bytes;
            r_fsize  <= i_frame_size;
            r_nest   <= i_nesting_level;
            r_dkind  <= i_dest_kind;
            r_daddr  <= i_dest_addr;
        end
    end

    // Form candidate addresses and window limits
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_t       <= r_sp - WORD_BYTES;
            r_t2      <= r_sp - (64'(r_fsize) + WORD_BYTES);
            r_sp_p8   <= r_sp + WORD_BYTES;
            r_fp_p8   <= r_fp + WORD_BYTES;
            r_hi_m8   <= r_stack_high - WORD_BYTES;
            r_hi_mf   <= r_stack_high - 64'(r_fsize);
            r_hi_mo   <= r_stack_high - 64'(r_obytes);
            r_len8_ok <= WORD_BYTES <= r_stack_high;
            r_lenf_ok <= 64'(r_fsize) <= r_stack_high;
            r_leno_ok <= 64'(r_obytes) <= r_stack_high;
        end
    end

    // Primary stack access address
    always_comb begin
        case (r_op)
            OP_ENTER, OP_PUSHFQ, OP_PUSH: addr1 = r_t;
            OP_LEAVE:                     addr1 = r_fp;
            default:                      addr1 = r_sp;
        endcase
    end

    sfe_bounds u_chk1 (
        .i_addr       (addr1),
        .i_low        (r_stack_low),
        .i_high_m_len (r_hi_m8),
        .i_len_ok     (r_len8_ok),
        .o_chk        (chk1)
    );

    sfe_bounds u_chk2 (
        .i_addr       (r_t2),
        .i_low        (r_stack_low),
        .i_high_m_len (r_hi_mf),
        .i_len_ok     (r_lenf_ok),
        .o_chk        (chk2)
    );

    sfe_bounds u_chkd (
        .i_addr       (r_daddr),
        .i_low        (r_stack_low),
        .i_high_m_len (r_hi_mo),
        .i_len_ok     (r_leno_ok),
        .o_chk        (chkd)
    );

    // Hold check outcomes
    always_ff @(posedge i_clk) begin
        if (r_state == S_CHK) begin
            r_ok1 <= chk1.ok;
            r_ok2 <= chk2.ok;
            r_okd <= chkd.ok;
        end
    end

    sfe_word_index #(.DEPTH(STACK_WORDS), .IW(IW)) u_idx1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_CHK),
        .i_offs  (chk1.offs),
        .o_done  (idx1_done),
        .o_idx   (idx1)
    );

    sfe_word_index #(.DEPTH(STACK_WORDS), .IW(IW)) u_idxd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_CHK),
        .i_offs  (chkd.offs),
        .o_done  (idxd_done),
        .o_idx   (idxd)
    );

    // Memory access decode
    assign op_write = ((r_op == OP_ENTER) && (r_nest == 5'd0)) ||
                      (r_op == OP_PUSHFQ) || (r_op == OP_PUSH);
    assign op_read  = (r_op == OP_LEAVE) || (r_op == OP_POPFQ) || (r_op == OP_POP);
    assign pop_win_wr = (r_op == OP_POP) && (r_dkind == DK_MEM) && r_ok1 && r_okd;

    always_comb begin
        case (r_op)
            OP_ENTER:  push_data = r_fp;
            OP_PUSHFQ: push_data = r_flags;
            default:   push_data = r_pval & size_mask(r_obytes);
        endcase
    end

    assign mem_we    = ((r_state == S_MEM) && op_write && r_ok1) ||
                       ((r_state == S_RD) && pop_win_wr);
    assign mem_waddr = (r_state == S_RD) ? idxd : idx1;
    assign mem_wdata = (r_state == S_RD) ? (mem_rdata & size_mask(r_obytes)) : push_data;
    assign mem_re    = (r_state == S_MEM) && op_read && r_ok1;

    sfe_stack_mem #(.DEPTH(STACK_WORDS), .AW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (idx1),
        .o_rdata (mem_rdata)
    );

    // Build the result
    always_comb begin : p_result
        logic [63:0] mval;
        mval         = mem_rdata & size_mask(r_obytes);
        res_status   = ST_OK;
        res_sp       = r_sp;
        res_fp       = r_fp;
        res_reg_wv   = 1'b0;
        res_reg_data = '0;
        res_mem_wv   = 1'b0;
        res_mem_addr = '0;
        res_mem_data = '0;
        res_flags_wv = 1'b0;
        res_flags    = '0;
        case (r_op)
            OP_ENTER: begin
                if (r_nest != 5'd0) begin
                    res_status = ST_NEST;
                end else if (!r_ok1) begin
                    res_status = ST_BOUNDS;
                end else begin
                    res_fp = r_t;
                    if (!r_ok2) begin
                        res_status = ST_BOUNDS;
                    end else begin
                        res_sp = r_t2;
                    end
                end
            end
            OP_LEAVE: begin
                if (!r_ok1) begin
                    res_status = ST_BOUNDS;
                end else begin
                    res_fp = mem_rdata;
                    res_sp = r_fp_p8;
                end
            end
            OP_PUSHFQ, OP_PUSH: begin
                if (!r_ok1) begin
                    res_status = ST_BOUNDS;
                end else begin
                    res_sp = r_t;
                end
            end
            OP_POPFQ: begin
                if (!r_ok1) begin
                    res_status = ST_BOUNDS;
                end else begin
                    res_flags_wv = 1'b1;
                    res_flags    = mem_rdata;
                    res_sp       = r_sp_p8;
                end
            end
            OP_POP: begin
                if (!r_ok1) begin
                    res_status = ST_BOUNDS;
                end else if (r_dkind == DK_REG) begin
                    res_reg_wv   = 1'b1;
                    res_reg_data = mval;
                    res_sp       = r_sp_p8;
                end else if (r_dkind == DK_MEM) begin
                    if (!r_okd) begin
                        res_mem_wv   = 1'b1;
                        res_mem_addr = r_daddr;
                        res_mem_data = mval;
                    end
                    res_sp = r_sp_p8;
                end else begin
                    res_status = ST_BAD;
                end
            end
            default: res_status = ST_BAD;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_ADDR;
            S_ADDR: n_state = S_CHK;
            S_CHK:  n_state = S_IDX;
            S_IDX:  if (idx1_done && idxd_done) n_state = S_MEM;
            S_MEM:  n_state = op_read ? S_RD : S_FIN;
            S_RD:   n_state = S_FIN;
            S_FIN:  if (fin_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register: load when empty or being drained
    assign fin_load = (r_state == S_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (fin_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            o_status            <= res_status;
            o_stack_ptr_out     <= res_sp;
            o_frame_ptr_out     <= res_fp;
            o_reg_write_valid   <= res_reg_wv;
            o_reg_data          <= res_reg_data;
            o_mem_write_valid   <= res_mem_wv;
            o_mem_addr          <= res_mem_addr;
            o_mem_data          <= res_mem_data;
            o_flags_write_valid <= res_flags_wv;
            o_flags_data        <= res_flags;
        end
    end

    assign o_valid = r_out_valid;

    // Checks
    `SFE_ASSERT_IMP(a_no_write_idle, i_clk, i_rst_n, (r_state == S_IDLE) || (r_state == S_FIN), !mem_we, "stack write outside memory steps")
    `SFE_ASSERT_IMP(a_mem_after_index, i_clk, i_rst_n, r_state == S_MEM, idx1_done && idxd_done, "memory step before index ready")
    `SFE_ASSERT_IMP(a_fault_no_effects, i_clk, i_rst_n, o_valid && (o_status != ST_OK), !o_reg_write_valid && !o_mem_write_valid && !o_flags_write_valid, "fault result carries a write")
    `SFE_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready, r_state == S_ADDR, "accepted item did not start")

endmodule
